>>> rtl/tst_pkg.sv
// Package for the tagged section timer table: widths, codes and shared types.
// No dependencies.
`default_nettype none
package tst_pkg;
  localparam int SLOTS = 16;
  localparam int TIME_BITS = 48;
  localparam int TAG_BITS = 16;
  localparam int IDX_BITS = $clog2(SLOTS);

  typedef logic [1:0] func_t;
  localparam func_t FUNC_BEGIN = 2'd0;
  localparam func_t FUNC_END = 2'd1;
  localparam func_t FUNC_RESET = 2'd2;
  localparam func_t FUNC_READ = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_STARTED = 3'd0;
  localparam status_t ST_RUNNING = 3'd1;
  localparam status_t ST_FULL = 3'd2;
  localparam status_t ST_ENDED = 3'd3;
  localparam status_t ST_END_IGN = 3'd4;
  localparam status_t ST_RESET = 3'd5;
  localparam status_t ST_READ_HIT = 3'd6;
  localparam status_t ST_READ_MISS = 3'd7;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE, S_SEND} state_t;

  // Statistics of one slot.
  typedef struct packed {
    logic [31:0] calls;
    logic [55:0] total;
    logic [47:0] max_top;
    logic [47:0] max_second;
    logic [47:0] min_low;
    logic [47:0] min_second;
  } stats_t;

  // Full contents of one slot as it travels along the ring.
  typedef struct packed {
    logic used;
    logic running;
    logic [TAG_BITS-1:0] tag;
    logic [TIME_BITS-1:0] start;
    stats_t st;
  } entry_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;
endpackage
`default_nettype wire

>>> rtl/tagged_section_timer_table.sv
// Top level of the tagged section timer table: ring of slot cells and sequencer.
// Depends on tst_pkg and tst_cell.
//
// Channel  | Ports                               | Handshake
// command  | func, tag, time_now                 | start high while busy low
// result   | status, slot, elapsed, stats fields | strobe high for one cycle
//
// A begin, end or read passes through the scan, update and send states before its
// result: one full rotation of the ring finds the tag and the lowest free slot, a
// second rotation writes the updated entry back at its slot, then the send state
// registers the result strobe. busy drops after the strobe, so the next command waits.
// A reset of statistics clears the slots when accepted and goes straight to send.
// rst is synchronous and clears the used, running and statistics bits of all slots.
// The receiver cannot stall; the result is shown for exactly one cycle.
`default_nettype none
module tagged_section_timer_table (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] func,
  input  wire logic [15:0] tag,
  input  wire logic [47:0] time_now,
  output logic strobe,
  output logic [2:0] status,
  output logic [3:0] slot,
  output logic [47:0] elapsed,
  output logic [31:0] call_count,
  output logic [55:0] total_time,
  output logic [47:0] max_top,
  output logic [47:0] max_second,
  output logic [47:0] min_low,
  output logic [47:0] min_second
);
  import tst_pkg::*;

  localparam logic [31:0] CALLS_MAX = '1;
  localparam logic [55:0] TOTAL_MAX = '1;

  state_t state, state_next;
  entry_t ring [SLOTS];
  entry_t head_in;
  cell_ctl_t ctl;

  logic accept;
  logic [1:0] cmd_func;
  logic [TAG_BITS-1:0] cmd_tag;
  logic [TIME_BITS-1:0] cmd_time;
  logic [IDX_BITS-1:0] cnt;
  logic hit, free_ok;
  logic [IDX_BITS-1:0] hit_idx, free_idx;
  logic [TIME_BITS-1:0] dur;
  stats_t res_st;
  logic res_has;
  logic target_run, dur_ok;

  // A command transfers only while no earlier command or result is pending.
  assign accept = start && !busy;

  // Ring of cells; cell 0 feeds from the head modify path.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    tst_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl),
      .ent_in((i == 0) ? head_in : ring[(i + SLOTS - 1) % SLOTS]),
      .ent_out(ring[i])
    );
  end

  entry_t tail;
  logic tail_match;
  logic [IDX_BITS-1:0] target;
  entry_t upd;
  logic [TIME_BITS-1:0] t;
  logic [56:0] sum;

  assign tail = ring[SLOTS-1];
  assign tail_match = tail.used && (tail.tag == cmd_tag);
  assign target = hit ? hit_idx : free_idx;

  // Update of the entry that comes round at the target position.
  always_comb begin
    upd = tail;
    t = cmd_time - tail.start;
    sum = {1'b0, tail.st.total} + {9'd0, t};
    if (cmd_func == FUNC_BEGIN && !(hit && tail.running)) begin
      upd.used = 1'b1;
      upd.tag = cmd_tag;
      upd.start = cmd_time;
      upd.running = 1'b1;
      if (tail.st.calls != CALLS_MAX) upd.st.calls = tail.st.calls + 32'd1;
    end else if (cmd_func == FUNC_END && hit && tail.running) begin
      upd.running = 1'b0;
      upd.st.total = sum[56] ? TOTAL_MAX : sum[55:0];
      if (tail.st.max_second < t) begin
        if (tail.st.max_top < t) begin
          upd.st.max_second = tail.st.max_top;
          upd.st.max_top = t;
        end else begin
          upd.st.max_second = t;
        end
      end else if (tail.st.min_second > t || tail.st.min_second == '0) begin
        if (tail.st.min_low > t || tail.st.min_low == '0) begin
          upd.st.min_second = tail.st.min_low;
          upd.st.min_low = t;
        end else begin
          upd.st.min_second = t;
        end
      end
    end
  end

  // Second pass: update cycle rotates once more with modification at the target.
  logic [IDX_BITS-1:0] upd_cnt;
  logic pass2;
  always_comb begin
    head_in = tail;
    if (pass2 && upd_cnt == target && (hit || free_ok)) head_in = upd;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (accept) state_next = (func == FUNC_RESET) ? S_SEND : S_SCAN;
        ctl.clear = accept && (func == FUNC_RESET);
      end
      S_SCAN: begin
        ctl.shift = 1'b1;
        if (cnt == IDX_BITS'(SLOTS - 1)) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        ctl.shift = 1'b1;
        if (upd_cnt == IDX_BITS'(SLOTS - 1)) state_next = S_SEND;
      end
      S_SEND: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
  assign pass2 = (state == S_UPDATE);

  // Capture of the command, scan bookkeeping and result register.
  logic [2:0] res_status;
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      upd_cnt <= '0;
      hit <= 1'b0;
      free_ok <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= (state == S_SEND);
      if (state == S_IDLE && accept) begin
        cmd_func <= func;
        cmd_tag <= tag[TAG_BITS-1:0];
        cmd_time <= time_now[TIME_BITS-1:0];
        cnt <= '0;
        upd_cnt <= '0;
        hit <= 1'b0;
        free_ok <= 1'b0;
        hit_idx <= '0;
        free_idx <= '0;
        dur <= '0;
      end
      if (state == S_SCAN) begin
        cnt <= cnt + 1'b1;
        if (tail_match && !hit) begin
          hit <= 1'b1;
          hit_idx <= cnt;
        end
        if (!tail.used && !free_ok) begin
          free_ok <= 1'b1;
          free_idx <= cnt;
        end
      end
      if (state == S_UPDATE) begin
        upd_cnt <= upd_cnt + 1'b1;
        if (upd_cnt == target && (hit || free_ok)) begin
          res_st <= head_in.st;
          if (cmd_func == FUNC_END && hit && tail.running) dur <= t;
        end
      end
    end
  end

  // Ring position 0 in scan order is the slot in cell SLOTS-1 at start, which is slot 0.
  always_comb begin
    res_status = ST_READ_MISS;
    res_has = hit;
    case (cmd_func)
      FUNC_BEGIN: begin
        if (hit) res_status = target_run ? ST_RUNNING : ST_STARTED;
        else if (free_ok) begin
          res_status = ST_STARTED;
          res_has = 1'b1;
        end else res_status = ST_FULL;
      end
      FUNC_END: res_status = (hit && dur_ok) ? ST_ENDED : ST_END_IGN;
      FUNC_RESET: begin
        res_status = ST_RESET;
        res_has = 1'b0;
      end
      FUNC_READ: res_status = hit ? ST_READ_HIT : ST_READ_MISS;
      default: res_status = ST_READ_MISS;
    endcase
  end

  // Running flag of the hit slot, recorded during the scan.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) target_run <= 1'b0;
    else if (state == S_SCAN && tail_match && !hit) target_run <= tail.running;
  end
  assign dur_ok = target_run;

  assign busy = (state != S_IDLE) || strobe;
  assign status = strobe ? res_status : '0;
  assign slot = (strobe && res_has) ? 4'(target) : 4'd0;
  assign elapsed = (strobe && cmd_func == FUNC_END && hit && dur_ok) ? dur : '0;
  assign call_count = (strobe && res_has) ? res_st.calls : '0;
  assign total_time = (strobe && res_has) ? res_st.total : '0;
  assign max_top = (strobe && res_has) ? res_st.max_top : '0;
  assign max_second = (strobe && res_has) ? res_st.max_second : '0;
  assign min_low = (strobe && res_has) ? res_st.min_low : '0;
  assign min_second = (strobe && res_has) ? res_st.min_second : '0;

  // Checks on the sequencer.
  a_strobe_after_send: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) |=> strobe) else $error("result not issued");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("busy low during result");
  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && cnt == IDX_BITS'(SLOTS - 1)) |=> (state == S_UPDATE))
    else $error("scan length wrong");
endmodule
`default_nettype wire

>>> rtl/tst_cell.sv
// One slot of the table; cells form a ring that rotates one place per cycle while shift is high.
// Depends on tst_pkg.
`default_nettype none
module tst_cell (
  input  wire logic clk,
  input  wire logic rst,
  input  tst_pkg::cell_ctl_t ctl,
  input  tst_pkg::entry_t ent_in,
  output tst_pkg::entry_t ent_out
);
  import tst_pkg::*;

  logic used;
  logic running;
  logic [TAG_BITS-1:0] tag;
  logic [TIME_BITS-1:0] start;
  stats_t st;

  // Control bits reset; the tag and start time stay undefined until written.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      running <= 1'b0;
      st <= '0;
    end else if (ctl.shift) begin
      used <= ent_in.used;
      running <= ent_in.running;
      st <= ent_in.st;
    end else if (ctl.clear && used) begin
      running <= 1'b0;
      st <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      tag <= ent_in.tag;
      start <= ent_in.start;
    end
  end

  assign ent_out = {used, running, tag, start, st};
endmodule
`default_nettype wire
